>>> hw/rtl/bres_pkg.sv
// Shared constants, command codes and width helpers for the line rasterizer.
package bres_pkg;

   // Default coordinate width and depth of the queue between front and back.
   localparam int COORD_BITS_DEFAULT = 10;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Extra bits that the signed decision term and increments need.
   localparam int TERM_EXTRA_BITS = 3;

   // Command carried on the request tuser bit.
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_NEXT  = 1'b1
   } cmd_type;

   // Width of the signed error term and increments.
   function automatic int term_bits(input int coord_bits);
      return coord_bits + TERM_EXTRA_BITS;
   endfunction

   // Width of one queued job: five flags, three coordinates, three terms.
   function automatic int job_bits(input int coord_bits);
      return 5 + 3 * coord_bits + 3 * term_bits(coord_bits);
   endfunction

   // Request tdata carries four coordinates, padded to whole bytes.
   function automatic int req_data_bits(input int coord_bits);
      return ((4 * coord_bits + 7) / 8) * 8;
   endfunction

   // Response tdata carries two coordinates, padded to whole bytes.
   function automatic int rsp_data_bits(input int coord_bits);
      return ((2 * coord_bits + 7) / 8) * 8;
   endfunction

endpackage

>>> hw/rtl/bres_front.sv
// Request decoder: classifies commands and sets up a line for the back end.
module bres_front #(
   parameter int COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [bres_pkg::req_data_bits(COORD_BITS)-1:0] req_tdata,
   input  logic                                          req_tuser,
   input  logic                                          queue_full,
   output logic                                          push,
   output logic [bres_pkg::job_bits(COORD_BITS)-1:0]      push_job
);

   localparam int CB = COORD_BITS;
   localparam int EB = bres_pkg::term_bits(COORD_BITS);

   typedef struct packed {
      logic                 is_start;
      logic                 zero_len;
      logic                 steep;
      logic                 minor_down;
      logic                 minor_delta_zero;
      logic [CB-1:0]        x0;
      logic [CB-1:0]        y0;
      logic [CB-1:0]        major_end;
      logic signed [EB-1:0] err_term;
      logic signed [EB-1:0] inc_straight;
      logic signed [EB-1:0] inc_diag;
   } job_type;

   logic [CB-1:0]        xs, ys, xe, ye;
   logic [CB-1:0]        dx, dy, maj, mnr;
   logic [CB-1:0]        x0, y0, x1, y1;
   logic                 steep, swap;
   logic signed [EB-1:0] maj_ext, mnr_ext;
   job_type              job;

   // Accept whenever the queue has room; every transaction becomes one job.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Endpoint fields from the lowest bits up.
   assign xs = req_tdata[CB-1:0];
   assign ys = req_tdata[2*CB-1:CB];
   assign xe = req_tdata[3*CB-1:2*CB];
   assign ye = req_tdata[4*CB-1:3*CB];

   // Absolute deltas, major axis choice and endpoint ordering.
   always_comb begin
      dx    = (xs > xe) ? (xs - xe) : (xe - xs);
      dy    = (ys > ye) ? (ys - ye) : (ye - ys);
      steep = (dx < dy);
      swap  = steep ? (ys > ye) : (xs > xe);
      x0    = swap ? xe : xs;
      y0    = swap ? ye : ys;
      x1    = swap ? xs : xe;
      y1    = swap ? ys : ye;
      maj   = steep ? dy : dx;
      mnr   = steep ? dx : dy;
   end

   // Decision term and increments, all in signed term width.
   assign maj_ext = {{(EB-CB){1'b0}}, maj};
   assign mnr_ext = {{(EB-CB){1'b0}}, mnr};

   always_comb begin
      job.is_start         = (req_tuser == bres_pkg::CMD_START);
      job.zero_len         = (dx == '0) && (dy == '0);
      job.steep            = steep;
      job.minor_down       = steep ? (x1 < x0) : (y1 < y0);
      job.minor_delta_zero = (mnr == '0);
      job.x0               = x0;
      job.y0               = y0;
      job.major_end        = steep ? y1 : x1;
      job.err_term         = (mnr_ext <<< 1) - maj_ext;
      job.inc_straight     = mnr_ext <<< 1;
      job.inc_diag         = (mnr_ext - maj_ext) <<< 1;
   end

   assign push_job = job;

endmodule

>>> hw/rtl/bres_queue.sv
// Small FIFO of decoded jobs between the front and the back end.
module bres_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bres_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and count updates with wrap at the last slot.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots carry no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The count never passes the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count exceeds depth");

   // Nothing is taken from an empty queue or written into a full one.
   assert property (@(posedge clock) disable iff (reset) !(pop && empty) && !(push && full))
      else $error("queue overflow or underflow");

   // The count rises by one on a push without a pop.
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

>>> hw/rtl/bres_back.sv
// Line stepper: holds the line state and produces one result per job.
module bres_back #(
   parameter int COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          queue_empty,
   input  logic [bres_pkg::job_bits(COORD_BITS)-1:0]      pop_job,
   output logic                                          pop,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [bres_pkg::rsp_data_bits(COORD_BITS)-1:0] rsp_tdata,
   output logic                                          rsp_tlast,
   output logic                                          rsp_tuser
);

   localparam int CB = COORD_BITS;
   localparam int EB = bres_pkg::term_bits(COORD_BITS);
   localparam int OB = bres_pkg::rsp_data_bits(COORD_BITS);

   typedef struct packed {
      logic                 is_start;
      logic                 zero_len;
      logic                 steep;
      logic                 minor_down;
      logic                 minor_delta_zero;
      logic [CB-1:0]        x0;
      logic [CB-1:0]        y0;
      logic [CB-1:0]        major_end;
      logic signed [EB-1:0] err_term;
      logic signed [EB-1:0] inc_straight;
      logic signed [EB-1:0] inc_diag;
   } job_type;

   job_type job;

   // Line state.
   logic                 busy_ff, busy_in;
   logic                 steep_ff, steep_in;
   logic                 minor_down_ff, minor_down_in;
   logic                 mdz_ff, mdz_in;
   logic [CB-1:0]        cur_x_ff, cur_x_in;
   logic [CB-1:0]        cur_y_ff, cur_y_in;
   logic [CB-1:0]        major_end_ff, major_end_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic signed [EB-1:0] inc_s_ff, inc_s_in;
   logic signed [EB-1:0] inc_d_ff, inc_d_in;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   logic                 pix_valid_ff, pix_valid_in;
   logic [CB-1:0]        pix_x_ff, pix_x_in;
   logic [CB-1:0]        pix_y_ff, pix_y_in;
   logic                 pix_last_ff, pix_last_in;

   logic [CB-1:0]        major_cur, minor_cur, major_nxt, minor_nxt;
   logic                 step_last;

   assign job = pop_job;

   // Take a job when one is queued and the output register is free or draining.
   assign pop = !queue_empty && (!out_valid_ff || rsp_tready);

   // One Bresenham step along the major axis.
   always_comb begin
      major_cur = steep_ff ? cur_y_ff : cur_x_ff;
      minor_cur = steep_ff ? cur_x_ff : cur_y_ff;
      major_nxt = major_cur + 1'b1;
      minor_nxt = minor_cur;
      if (!err_ff[EB-1] && !mdz_ff) begin
         minor_nxt = minor_down_ff ? minor_cur - 1'b1 : minor_cur + 1'b1;
      end
      step_last = (major_nxt == major_end_ff);
   end

   // Next state of the line and the output register.
   always_comb begin
      busy_in       = busy_ff;
      steep_in      = steep_ff;
      minor_down_in = minor_down_ff;
      mdz_in        = mdz_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      major_end_in  = major_end_ff;
      err_in        = err_ff;
      inc_s_in      = inc_s_ff;
      inc_d_in      = inc_d_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      pix_valid_in  = pix_valid_ff;
      pix_x_in      = pix_x_ff;
      pix_y_in      = pix_y_ff;
      pix_last_in   = pix_last_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         if (job.is_start) begin
            // A start abandons any line in progress and emits the lower endpoint.
            cur_x_in     = job.x0;
            cur_y_in     = job.y0;
            busy_in      = !job.zero_len;
            pix_valid_in = 1'b1;
            pix_x_in     = job.x0;
            pix_y_in     = job.y0;
            pix_last_in  = job.zero_len;
            if (!job.zero_len) begin
               steep_in      = job.steep;
               minor_down_in = job.minor_down;
               mdz_in        = job.minor_delta_zero;
               major_end_in  = job.major_end;
               err_in        = job.err_term;
               inc_s_in      = job.inc_straight;
               inc_d_in      = job.inc_diag;
            end
         end else if (busy_ff) begin
            // Advance one pixel along the line.
            cur_x_in     = steep_ff ? minor_nxt : major_nxt;
            cur_y_in     = steep_ff ? major_nxt : minor_nxt;
            err_in       = err_ff[EB-1] ? (err_ff + inc_s_ff) : (err_ff + inc_d_ff);
            busy_in      = !step_last;
            pix_valid_in = 1'b1;
            pix_x_in     = steep_ff ? minor_nxt : major_nxt;
            pix_y_in     = steep_ff ? major_nxt : minor_nxt;
            pix_last_in  = step_last;
         end else begin
            // A next command with no line in progress gives an empty result.
            pix_valid_in = 1'b0;
            pix_x_in     = '0;
            pix_y_in     = '0;
            pix_last_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         steep_ff      <= 1'b0;
         minor_down_ff <= 1'b0;
         mdz_ff        <= 1'b0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         major_end_ff  <= '0;
         err_ff        <= '0;
         inc_s_ff      <= '0;
         inc_d_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         steep_ff      <= steep_in;
         minor_down_ff <= minor_down_in;
         mdz_ff        <= mdz_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         major_end_ff  <= major_end_in;
         err_ff        <= err_in;
         inc_s_ff      <= inc_s_in;
         inc_d_ff      <= inc_d_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Pixel payload needs no reset.
   always_ff @(posedge clock) begin
      pix_valid_ff <= pix_valid_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_last_ff  <= pix_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OB'({pix_y_ff, pix_x_ff});
   assign rsp_tlast  = pix_last_ff;
   assign rsp_tuser  = pix_valid_ff;

   // A last pixel is always a real pixel.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && pix_last_ff) |-> pix_valid_ff)
      else $error("last flag on an empty result");

   // A step that reaches the far endpoint ends the line.
   assert property (@(posedge clock) disable iff (reset)
      (pop && !job.is_start && busy_ff && step_last) |=> !busy_ff)
      else $error("line still busy after its last pixel");

   // A start of nonzero length leaves a line in progress.
   assert property (@(posedge clock) disable iff (reset)
      (pop && job.is_start && !job.zero_len) |=> busy_ff)
      else $error("line not started");

   // A stalled result register is not overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !pop)
      else $error("job taken while the result register is stalled");

endmodule

>>> hw/rtl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer with a pixel-pull interface.
//
// Request channel (req_): one transaction per command. tuser is the command:
// start a line from the two endpoints in tdata, or pull the next pixel.
// Response channel (rsp_): exactly one transaction per request, in order.
// tuser says whether a pixel was produced, tlast marks the far endpoint.
// A start emits the endpoint that is lower along the major axis; each next
// emits one more pixel; a next with no line in progress gives tuser low.
// The job is written into the queue when the request is accepted and
// is then loaded from the queue into the output register. The block
// sustains one transaction per cycle while the receiver takes responses,
// as the error update and pixel step in the back end are combinational.
// The front end decodes each request into a job and pushes it into a
// four-entry queue; the back end pops jobs while its output register is
// free or draining. When the receiver stalls, the output register holds
// its pixel, the queue fills, and req_tready falls once the queue is full.
// Synchronous reset empties the queue, drops any line in progress and
// clears the line state to zero.
module bresenham_line_rasterizer #(
   parameter int COORD_BITS = bres_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // tdata from bit 0: x_start, y_start, x_end, y_end, zero padding
   input  logic [bres_pkg::req_data_bits(COORD_BITS)-1:0] req_tdata,
   // tuser: cmd
   input  logic                                          req_tuser,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // tdata from bit 0: pixel_x, pixel_y, zero padding
   output logic [bres_pkg::rsp_data_bits(COORD_BITS)-1:0] rsp_tdata,
   // tuser: pixel_valid
   output logic                                          rsp_tuser,
   output logic                                          rsp_tlast
);

   localparam int JB = bres_pkg::job_bits(COORD_BITS);

   logic          push, pop, queue_full, queue_empty;
   logic [JB-1:0] push_job, pop_job;

   bres_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   bres_queue #(
      .WIDTH(JB),
      .DEPTH(bres_pkg::QUEUE_DEPTH_DEFAULT)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   bres_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
